@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PWN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PWN_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/pwn_pkg.sv @@
package pwn_pkg;

   localparam int COORD_W          = 24;
   localparam int PROD_W           = 2 * COORD_W;
   localparam int AREA_W           = 64;
   localparam int STATUS_W         = 2;
   localparam int MIN_VERTICES     = 3;
   localparam int MAX_VERTICES_DEF = 64;
   localparam int CMD_FIFO_DEPTH   = 2;
   localparam int CSR_DATA_W       = 32;
   localparam int CSR_ADDR_W       = 2;

   localparam logic [CSR_ADDR_W-1:0] ADDR_TARGET_WINDING = '0;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK  = 2'd0,
      ST_FEW = 2'd1,
      ST_OVF = 2'd2
   } status_type;

   // One closed polygon handed from loader to emitter.
   typedef struct packed {
      logic       bank;
      logic       reverse;
      logic       wind;
      status_type status;
   } cmd_type;

   // Emitter returns a vertex bank once its last vertex is out.
   typedef struct packed {
      logic done;
      logic bank;
   } release_type;

endpackage

@@ rtl/core/polygon_winding_normalizer_top.sv @@
// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_ready     vert_x, vert_y, closes_polygon
// rsp       out        rsp_valid / rsp_ready     out_x, out_y, found_winding, status,
//                                                final_vertex
// csr       in/out     psel, penable, pready     target_winding at byte address 0
//
// Loading takes one vertex item per cycle while req_ready is high; an ok close then runs the
// loader's closing-edge multiply, area add and queue write states, an error close only the
// queue write; a full queue holds it. An idle emitter pops a polygon; its items are read from
// the store, then registered, one item per cycle unless stalled; an error item, at the pop.
// Two vertex banks: loading stalls while both hold polygons not yet fully sent.
// Reset is synchronous; the vertex store has no clearing pass.
`include "assert_macros.svh"

module polygon_winding_normalizer_top
   import pwn_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [COORD_W-1:0]   req_vert_x,
   input  logic signed [COORD_W-1:0]   req_vert_y,
   input  logic                        req_closes_polygon,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [COORD_W-1:0]   rsp_out_x,
   output logic signed [COORD_W-1:0]   rsp_out_y,
   output logic                        rsp_found_winding,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic                        rsp_final_vertex,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [CSR_DATA_W-1:0]       csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int AW = $clog2(2 * MAX_VERTICES);
   localparam int FW = $bits(cmd_type) + CW;

   logic                target_ff;
   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [2*COORD_W-1:0] ram_wdata, ram_rdata;
   logic                cmd_push, cmd_pop, cmd_full, cmd_empty;
   cmd_type             cmd_wr, cmd_rd;
   logic [CW-1:0]       last_wr, last_rd;
   logic [FW-1:0]       fifo_rdata;
   release_type         rel;
   logic [1:0]          bank_busy;
   status_type          back_status;
   logic                rsp_err, err_item_zero, rel_bank_busy;

   // one register at byte address 0
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(CSR_DATA_W - 1){1'b0}}, target_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == ADDR_TARGET_WINDING)) begin
         target_ff <= csr_pwdata[0];
      end
   end

   pwn_front #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .vert_x         (req_vert_x),
      .vert_y         (req_vert_y),
      .closes_polygon (req_closes_polygon),
      .target_winding (target_ff),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata),
      .cmd_push       (cmd_push),
      .cmd            (cmd_wr),
      .cmd_last       (last_wr),
      .cmd_full       (cmd_full),
      .rel            (rel),
      .bank_busy      (bank_busy)
   );

   pwn_ram #(
      .WIDTH(2 * COORD_W),
      .DEPTH(2 * MAX_VERTICES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pwn_cmd_fifo #(
      .WIDTH(FW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata ({cmd_wr, last_wr}),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (fifo_rdata),
      .empty (cmd_empty)
   );

   assign cmd_rd  = cmd_type'(fifo_rdata[FW-1:CW]);
   assign last_rd = fifo_rdata[CW-1:0];

   pwn_back #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_empty     (cmd_empty),
      .cmd           (cmd_rd),
      .cmd_last      (last_rd),
      .cmd_pop       (cmd_pop),
      .ram_re        (ram_re),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .out_x         (rsp_out_x),
      .out_y         (rsp_out_y),
      .found_winding (rsp_found_winding),
      .status        (back_status),
      .final_vertex  (rsp_final_vertex),
      .rel           (rel)
   );

   assign rsp_status = back_status;

   assign rsp_err       = rsp_valid && (rsp_status != ST_OK);
   assign err_item_zero = rsp_final_vertex && (rsp_out_x == '0) && (rsp_out_y == '0) &&
                          !rsp_found_winding;
   assign rel_bank_busy = bank_busy[rel.bank];

   `PWN_ASSERT_IMP(a_err_item_shape, clock, reset, rsp_err, err_item_zero, "error item fields wrong")
   `PWN_ASSERT_IMP(a_push_has_room, clock, reset, cmd_push, !cmd_full, "queue written while full")
   `PWN_ASSERT_IMP(a_release_busy, clock, reset, rel.done, rel_bank_busy, "release of idle bank")
   `PWN_ASSERT_NXT(a_rel_free, clock, reset, rel.done, !bank_busy[$past(rel.bank)], "bank kept busy")

endmodule

@@ rtl/core/pwn_ram.sv @@
module pwn_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/pwn_cmd_fifo.sv @@
module pwn_cmd_fifo
   import pwn_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = $clog2(CMD_FIFO_DEPTH);
   localparam int NW = $clog2(CMD_FIFO_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [CMD_FIFO_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full    = (fill_ff == NW'(CMD_FIFO_DEPTH));
   assign empty   = (fill_ff == '0);
   assign rdata   = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ rtl/core/pwn_front.sv @@
module pwn_front
   import pwn_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COORD_W-1:0]             vert_x,
   input  logic signed [COORD_W-1:0]             vert_y,
   input  logic                                  closes_polygon,
   input  logic                                  target_winding,
   output logic                                  ram_we,
   output logic [$clog2(2*MAX_VERTICES)-1:0]     ram_waddr,
   output logic [2*COORD_W-1:0]                  ram_wdata,
   output logic                                  cmd_push,
   output cmd_type                               cmd,
   output logic [$clog2(MAX_VERTICES+1)-1:0]     cmd_last,
   input  logic                                  cmd_full,
   input  release_type                           rel,
   output logic [1:0]                            bank_busy
);

   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int AW = $clog2(2 * MAX_VERTICES);

   typedef enum logic [1:0] {
      F_LOAD,
      F_MUL,
      F_ADD,
      F_PUSH
   } state_type;

   state_type                   state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        ovf_ff, ovf_in;
   logic signed [COORD_W-1:0]   prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [COORD_W-1:0]   first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [AREA_W-1:0]    area_ff, area_in;
   logic signed [PROD_W-1:0]    prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic                        acc_en_ff, acc_en_in;
   logic                        bank_ff, bank_in;
   logic [1:0]                  busy_ff, busy_in;
   status_type                  status_ff, status_in;

   logic                        accept, room, ovf_next;
   logic [CW-1:0]               n_next;
   logic signed [COORD_W-1:0]   mb1, ma2;
   logic signed [PROD_W:0]      diff;
   logic                        wind;

   assign req_ready = (state_ff == F_LOAD) && !busy_ff[bank_ff];
   assign accept    = req_valid && req_ready;
   assign room      = (count_ff != CW'(MAX_VERTICES));
   assign ovf_next  = ovf_ff || !room;
   assign n_next    = room ? count_ff + CW'(1) : count_ff;

   assign ram_we    = accept && room;
   assign ram_waddr = (bank_ff ? AW'(MAX_VERTICES) : AW'(0)) + AW'(count_ff);
   assign ram_wdata = {vert_x, vert_y};

   // closing edge reuses the multipliers: last vertex times first vertex
   assign mb1  = (state_ff == F_MUL) ? first_y_ff : vert_y;
   assign ma2  = (state_ff == F_MUL) ? first_x_ff : vert_x;
   assign diff = (PROD_W + 1)'(prod_a_ff) - (PROD_W + 1)'(prod_b_ff);
   assign wind = !area_ff[AREA_W-1];

   assign cmd_push     = (state_ff == F_PUSH) && !cmd_full;
   assign cmd.bank     = bank_ff;
   assign cmd.wind     = wind;
   assign cmd.reverse  = (wind != target_winding);
   assign cmd.status   = status_ff;
   assign cmd_last     = count_ff - CW'(1);
   assign bank_busy    = busy_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      bank_in    = bank_ff;
      busy_in    = busy_ff;
      status_in  = status_ff;
      prod_a_in  = prev_x_ff * mb1;
      prod_b_in  = ma2 * prev_y_ff;
      acc_en_in  = (accept && room && (count_ff != '0)) || (state_ff == F_MUL);
      area_in    = acc_en_ff ?
                   area_ff + {{(AREA_W - PROD_W - 1){diff[PROD_W]}}, diff} : area_ff;

      if (rel.done) begin
         busy_in[rel.bank] = 1'b0;
      end

      case (state_ff)
         F_LOAD: begin
            if (accept) begin
               count_in = n_next;
               ovf_in   = ovf_next;
               if (room) begin
                  prev_x_in = vert_x;
                  prev_y_in = vert_y;
                  if (count_ff == '0) begin
                     first_x_in = vert_x;
                     first_y_in = vert_y;
                  end
               end
               if (closes_polygon) begin
                  if (ovf_next) begin
                     status_in = ST_OVF;
                     state_in  = F_PUSH;
                  end else if (n_next < CW'(MIN_VERTICES)) begin
                     status_in = ST_FEW;
                     state_in  = F_PUSH;
                  end else begin
                     status_in = ST_OK;
                     state_in  = F_MUL;
                  end
               end
            end
         end
         F_MUL: begin
            state_in = F_ADD;
         end
         F_ADD: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (cmd_push) begin
               count_in  = '0;
               ovf_in    = 1'b0;
               prev_x_in = '0;
               prev_y_in = '0;
               area_in   = '0;
               state_in  = F_LOAD;
               if (status_ff == ST_OK) begin
                  busy_in[bank_ff] = 1'b1;
                  bank_in          = !bank_ff;
               end
            end
         end
         default: begin
            state_in = F_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_LOAD;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         area_ff   <= '0;
         acc_en_ff <= 1'b0;
         bank_ff   <= 1'b0;
         busy_ff   <= '0;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         area_ff   <= area_in;
         acc_en_ff <= acc_en_in;
         bank_ff   <= bank_in;
         busy_ff   <= busy_in;
         status_ff <= status_in;
      end
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prod_a_ff  <= prod_a_in;
      prod_b_ff  <= prod_b_in;
   end

endmodule

@@ rtl/core/pwn_back.sv @@
module pwn_back
   import pwn_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  cmd_empty,
   input  cmd_type                               cmd,
   input  logic [$clog2(MAX_VERTICES+1)-1:0]     cmd_last,
   output logic                                  cmd_pop,
   output logic                                  ram_re,
   output logic [$clog2(2*MAX_VERTICES)-1:0]     ram_raddr,
   input  logic [2*COORD_W-1:0]                  ram_rdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [COORD_W-1:0]             out_x,
   output logic signed [COORD_W-1:0]             out_y,
   output logic                                  found_winding,
   output status_type                            status,
   output logic                                  final_vertex,
   output release_type                           rel
);

   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int AW = $clog2(2 * MAX_VERTICES);

   logic                      active_ff, active_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [CW-1:0]             last_ff, last_in;
   logic                      bank_ff, bank_in;
   logic                      rev_ff, rev_in;
   logic                      wind_ff, wind_in;
   logic                      pend_ff, pend_in;
   logic                      pend_last_ff, pend_last_in;
   logic                      out_valid_ff, out_valid_in;
   logic signed [COORD_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                      out_wind_ff, out_wind_in;
   status_type                out_status_ff, out_status_in;
   logic                      out_final_ff, out_final_in;

   logic                      out_free, load, issue, last_issue, start, err_load;
   logic [CW-1:0]             idx;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign load       = pend_ff && out_free;
   assign issue      = active_ff && (!pend_ff || load);
   assign last_issue = (cnt_ff == last_ff);
   assign start      = !active_ff && !pend_ff && !cmd_empty &&
                       ((cmd.status == ST_OK) || out_free);
   assign err_load   = start && (cmd.status != ST_OK);
   assign cmd_pop    = start;

   assign idx       = rev_ff ? last_ff - cnt_ff : cnt_ff;
   assign ram_re    = issue;
   assign ram_raddr = (bank_ff ? AW'(MAX_VERTICES) : AW'(0)) + AW'(idx);

   assign rel.done = load && pend_last_ff;
   assign rel.bank = bank_ff;

   assign rsp_valid     = out_valid_ff;
   assign out_x         = out_x_ff;
   assign out_y         = out_y_ff;
   assign found_winding = out_wind_ff;
   assign status        = out_status_ff;
   assign final_vertex  = out_final_ff;

   always_comb begin
      active_in     = active_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      bank_in       = bank_ff;
      rev_in        = rev_ff;
      wind_in       = wind_ff;
      pend_in       = issue || (pend_ff && !load);
      pend_last_in  = issue ? last_issue : pend_last_ff;
      out_valid_in  = out_valid_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_wind_in   = out_wind_ff;
      out_status_in = out_status_ff;
      out_final_in  = out_final_ff;

      if (start && (cmd.status == ST_OK)) begin
         active_in = 1'b1;
         cnt_in    = '0;
         last_in   = cmd_last;
         bank_in   = cmd.bank;
         rev_in    = cmd.reverse;
         wind_in   = cmd.wind;
      end else if (issue) begin
         cnt_in = cnt_ff + CW'(1);
         if (last_issue) begin
            active_in = 1'b0;
         end
      end

      if (load) begin
         out_valid_in  = 1'b1;
         out_x_in      = ram_rdata[2*COORD_W-1:COORD_W];
         out_y_in      = ram_rdata[COORD_W-1:0];
         out_wind_in   = wind_ff;
         out_status_in = ST_OK;
         out_final_in  = pend_last_ff;
      end else if (err_load) begin
         out_valid_in  = 1'b1;
         out_x_in      = '0;
         out_y_in      = '0;
         out_wind_in   = 1'b0;
         out_status_in = cmd.status;
         out_final_in  = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff        <= cnt_in;
      last_ff       <= last_in;
      bank_ff       <= bank_in;
      rev_ff        <= rev_in;
      wind_ff       <= wind_in;
      pend_last_ff  <= pend_last_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_wind_ff   <= out_wind_in;
      out_status_ff <= out_status_in;
      out_final_ff  <= out_final_in;
   end

endmodule
